// ===== design/mnga_pkg.sv =====
// shared widths, register indexes, divider status and tick saturation for the groove applier
package mnga_pkg;

    localparam int TICK_W       = 32;
    localparam int VEL_W        = 7;
    localparam int PITCH_W      = 7;
    localparam int TPB_W        = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 64;
    localparam int POS_W        = 3;
    localparam int AXIS_DATA_W  = 80;

    localparam int DEVIATION_ENTRIES_DEF = 8;
    localparam int CURVE_ENTRIES_DEF     = 8;

    localparam logic [CFG_IDX_W-1:0] REG_DEV_TABLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEV_COUNT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VEL_TABLE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CURVE_CNT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TPB        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INTENSITY  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SWING      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 3'd7;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    function automatic logic [TICK_W-1:0] sat_tick(input logic signed [TICK_W+5:0] t);
        logic [TICK_W-1:0] res;
        if (t[TICK_W+5])
        begin
            res = '0;
        end
        else if (t[TICK_W+4:TICK_W] != '0)
        begin
            res = '1;
        end
        else
        begin
            res = t[TICK_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== design/mnga_div.sv =====
// serial restoring divider, one quotient bit per cycle, with a running quotient modulo count
module mnga_div
    import mnga_pkg::*;
#(
    parameter int MOD_MAX = CURVE_ENTRIES_DEF,
    parameter int MOD_W   = $clog2(MOD_MAX + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [TICK_W-1:0] dividend,
    input  logic [TPB_W-1:0]  divisor,
    input  logic [MOD_W-1:0]  modulus,
    output logic [MOD_W-1:0]  quotient_mod,
    output logic [TPB_W-1:0]  remainder,
    output div_status_t       status
);

    localparam int CNT_W = $clog2(TICK_W);

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [TICK_W-1:0] dvd_reg, dvd_next;
    logic [TPB_W-1:0]  rem_reg, rem_next;
    logic [MOD_W-1:0]  qmod_reg, qmod_next;

    logic [TPB_W:0]    rem_sh;
    logic              qbit;
    logic [MOD_W:0]    qmod_sh;

    always_comb
    begin
        rem_sh    = {rem_reg, dvd_reg[TICK_W-1]};
        qbit      = (rem_sh >= {1'b0, divisor});
        qmod_sh   = {qmod_reg, qbit};
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        qmod_next = qmod_reg;
        if (start)
        begin
            cnt_next  = '0;
            busy_next = 1'b1;
            dvd_next  = dividend;
            rem_next  = '0;
            qmod_next = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[TICK_W-2:0], 1'b0};
            if (qbit)
            begin
                rem_next = TPB_W'(rem_sh - {1'b0, divisor});
            end
            else
            begin
                rem_next = rem_sh[TPB_W-1:0];
            end
            if (qmod_sh >= {1'b0, modulus})
            begin
                qmod_next = MOD_W'(qmod_sh - {1'b0, modulus});
            end
            else
            begin
                qmod_next = qmod_sh[MOD_W-1:0];
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(TICK_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        qmod_reg <= qmod_next;
    end

    assign quotient_mod = qmod_reg;
    assign remainder    = rem_reg;
    assign status.busy  = busy_reg;
    assign status.done  = done_reg;

endmodule

// ===== design/midi_note_groove_applier.sv =====
// top level: applies timing deviation, velocity curve and swing to one midi note per transaction
// a note passes through the time, start, divide, velocity, swing and output states, one note in flight at a time
// a new note is taken only in idle, once the last one has passed the 32-step serial tick divider
// a finished result waits in the output register while the next note is taken in
// reset: registers return to defaults (tpb 480, intensity 256, swing 128, all enables),
// tables and counts clear, pattern position returns to 0
module midi_note_groove_applier
    import mnga_pkg::*;
#(
    parameter int DEVIATION_ENTRIES = DEVIATION_ENTRIES_DEF,
    parameter int CURVE_ENTRIES     = CURVE_ENTRIES_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // start_tick[31:0], note_velocity[38:32], pitch[45:39], duration_ticks[77:46]
    input  logic [AXIS_DATA_W-1:0] s_axis_tdata,
    // first_in_list[0]
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // new_start_tick[31:0], new_velocity[38:32], out_pitch[45:39], out_duration[77:46]
    output logic [AXIS_DATA_W-1:0] m_axis_tdata
);

    localparam int MOD_W = $clog2(CURVE_ENTRIES + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_TIME  = 7'b0000010,
        S_START = 7'b0000100,
        S_DIV   = 7'b0001000,
        S_VEL   = 7'b0010000,
        S_SWING = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [63:0]        dev_table_reg;
    logic [3:0]         dev_count_reg;
    logic [55:0]        vel_table_reg;
    logic [3:0]         curve_count_reg;
    logic [TPB_W-1:0]   tpb_reg;
    logic [8:0]         intensity_reg;
    logic [8:0]         swing_reg;
    logic [2:0]         enable_reg;
    logic [POS_W-1:0]   pos_reg, pos_next;

    logic [TICK_W-1:0]  tick_reg, tick_next;
    logic [VEL_W-1:0]   vel_in_reg;
    logic [VEL_W-1:0]   vel_res_reg, vel_res_next;
    logic [PITCH_W-1:0] pitch_reg;
    logic [TICK_W-1:0]  dur_reg;
    logic               first_reg;
    logic signed [19:0] m1_reg, m1_next;
    logic signed [36:0] m2_reg, m2_next;
    logic               offbeat_reg, offbeat_next;

    logic               out_valid_reg, out_valid_next;
    logic [AXIS_DATA_W-1:0] out_data_reg;

    logic [3:0]         dcount, ccount;
    logic [8:0]         inten, swing;
    logic [TPB_W-1:0]   tpb;
    logic signed [9:0]  inten_s;
    logic [POS_W-1:0]   idx_raw, idx;
    logic signed [7:0]  dev;
    logic signed [17:0] dev_prod, dev_off;
    logic signed [9:0]  sw_delta;
    logic [3:0]         idx_inc;

    logic [MOD_W-1:0]   quot_mod;
    logic [TPB_W-1:0]   div_rem;
    div_status_t        div_status;
    logic               div_start;

    logic [2:0]         curve_idx;
    logic [VEL_W-1:0]   target;
    logic [16:0]        blend;
    logic [VEL_W-1:0]   vel_blend;
    logic [TPB_W-1:0]   half, half_gap;
    logic [20:0]        dist20, tpb3;
    logic signed [36:0] swing_off;

    logic               in_accept, out_free;

    assign dcount  = (dev_count_reg > 4'(DEVIATION_ENTRIES)) ? 4'(DEVIATION_ENTRIES)
                                                             : dev_count_reg;
    assign ccount  = (curve_count_reg > 4'(CURVE_ENTRIES)) ? 4'(CURVE_ENTRIES)
                                                           : curve_count_reg;
    assign inten   = (intensity_reg > 9'd256) ? 9'd256 : intensity_reg;
    assign swing   = (swing_reg > 9'd256) ? 9'd256 : swing_reg;
    assign tpb     = (tpb_reg < 16'd2) ? 16'd2 : tpb_reg;
    assign inten_s = $signed({1'b0, inten});

    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign div_start     = (state_reg == S_START);

    mnga_div #(
        .MOD_MAX (CURVE_ENTRIES),
        .MOD_W   (MOD_W)
    ) u_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (div_start),
        .dividend     (tick_reg),
        .divisor      (tpb),
        .modulus      (MOD_W'(ccount)),
        .quotient_mod (quot_mod),
        .remainder    (div_rem),
        .status       (div_status)
    );

    // timing offset, pattern index and swing delta
    always_comb
    begin
        idx_raw  = first_reg ? '0 : pos_reg;
        idx      = ({1'b0, idx_raw} >= dcount) ? '0 : idx_raw;
        dev      = $signed(dev_table_reg[8*idx +: 8]);
        dev_prod = dev * inten_s;
        dev_off  = (dev_prod + (dev_prod[17] ? 18'sd255 : 18'sd0)) >>> 8;
        idx_inc  = {1'b0, idx} + 4'd1;
        sw_delta = $signed({1'b0, swing}) - 10'sd128;
    end

    // velocity blend, off-beat test and swing offset
    always_comb
    begin
        curve_idx = 3'(quot_mod);
        target    = vel_table_reg[7*curve_idx +: 7];
        blend     = 17'(vel_in_reg) * 17'(9'd256 - inten) + 17'(target) * 17'(inten);
        vel_blend = (blend[14:8] == '0) ? 7'd1 : blend[14:8];
        half      = {1'b0, tpb[TPB_W-1:1]};
        half_gap  = (div_rem >= half) ? (div_rem - half) : (half - div_rem);
        dist20    = 21'(half_gap) * 21'd20;
        tpb3      = 21'(tpb) * 21'd3;
        swing_off = (m2_reg + (m2_reg[36] ? 37'sd65535 : 37'sd0)) >>> 16;
    end

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        tick_next      = tick_reg;
        vel_res_next   = vel_res_reg;
        m1_next        = m1_reg;
        m2_next        = m2_reg;
        offbeat_next   = offbeat_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    tick_next  = s_axis_tdata[31:0];
                    state_next = S_TIME;
                end
            end
            S_TIME:
            begin
                if (enable_reg[0] && (dcount != '0))
                begin
                    tick_next = sat_tick($signed({6'b0, tick_reg}) + 38'(dev_off));
                end
                if (dcount != '0)
                begin
                    pos_next = (idx_inc >= dcount) ? '0 : idx_inc[POS_W-1:0];
                end
                else
                begin
                    pos_next = '0;
                end
                m1_next    = sw_delta * inten_s;
                state_next = S_START;
            end
            S_START:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_status.done)
                begin
                    state_next = S_VEL;
                end
            end
            S_VEL:
            begin
                vel_res_next = (enable_reg[1] && (ccount != '0)) ? vel_blend : vel_in_reg;
                m2_next      = m1_reg * $signed({1'b0, tpb[TPB_W-1:1], 1'b0});
                offbeat_next = (dist20 < tpb3);
                state_next   = S_SWING;
            end
            S_SWING:
            begin
                if (enable_reg[2] && (swing != 9'd128) && offbeat_reg)
                begin
                    tick_next = sat_tick($signed({6'b0, tick_reg}) + 38'(swing_off));
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            pos_reg         <= '0;
            out_valid_reg   <= 1'b0;
            dev_table_reg   <= '0;
            dev_count_reg   <= '0;
            vel_table_reg   <= '0;
            curve_count_reg <= '0;
            tpb_reg         <= 16'd480;
            intensity_reg   <= 9'd256;
            swing_reg       <= 9'd128;
            enable_reg      <= 3'd7;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DEV_TABLE: dev_table_reg   <= cfg_wdata;
                    REG_DEV_COUNT: dev_count_reg   <= cfg_wdata[3:0];
                    REG_VEL_TABLE: vel_table_reg   <= cfg_wdata[55:0];
                    REG_CURVE_CNT: curve_count_reg <= cfg_wdata[3:0];
                    REG_TPB:       tpb_reg         <= cfg_wdata[TPB_W-1:0];
                    REG_INTENSITY: intensity_reg   <= cfg_wdata[8:0];
                    REG_SWING:     swing_reg       <= cfg_wdata[8:0];
                    REG_ENABLE:    enable_reg      <= cfg_wdata[2:0];
                    default:       enable_reg      <= enable_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tick_reg    <= tick_next;
        vel_res_reg <= vel_res_next;
        m1_reg      <= m1_next;
        m2_reg      <= m2_next;
        offbeat_reg <= offbeat_next;
        if (in_accept)
        begin
            vel_in_reg <= s_axis_tdata[38:32];
            pitch_reg  <= s_axis_tdata[45:39];
            dur_reg    <= s_axis_tdata[77:46];
            first_reg  <= s_axis_tuser;
        end
        if ((state_reg == S_OUT) && out_free)
        begin
            out_data_reg <= {2'b00, dur_reg, pitch_reg, vel_res_reg, tick_reg};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for midi_note_groove_applier: directed table, then randomized groove settings
module tb_top
    import mnga_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES    = 300_000;
    localparam int RANDOM_PHASES   = 8;
    localparam int NOTES_PER_PHASE = 75;
    localparam int LONG_HOLD       = 300;
    localparam int TAIL_CYCLES     = 60;
    localparam longint TICK_MAX    = 64'h0000_0000_FFFF_FFFF;

    localparam logic [2:0] EN_TIMING   = 3'b001;
    localparam logic [2:0] EN_VELOCITY = 3'b010;
    localparam logic [2:0] EN_SWING    = 3'b100;
    localparam logic [2:0] EN_ALL      = EN_TIMING | EN_VELOCITY | EN_SWING;

    localparam int PH_RESET     = 0;
    localparam int PH_TIMING    = 1;
    localparam int PH_OVERRANGE = 2;
    localparam int PH_NO_TIMING = 3;
    localparam int PH_STALE_POS = 4;

    typedef struct {
        logic [TICK_W-1:0]  start_tick;
        logic [VEL_W-1:0]   velocity;
        logic [PITCH_W-1:0] pitch;
        logic [TICK_W-1:0]  duration;
        logic               first_in_list;
    } note_t;

    typedef struct {
        logic [TICK_W-1:0]  start_tick;
        logic [VEL_W-1:0]   velocity;
        logic [PITCH_W-1:0] pitch;
        logic [TICK_W-1:0]  duration;
    } groove_result_t;

    typedef struct {
        int                 phase;
        logic [TICK_W-1:0]  tick;
        logic [VEL_W-1:0]   vel;
        logic [PITCH_W-1:0] pitch;
        logic [TICK_W-1:0]  dur;
        logic               first;
        bit                 typed;
        logic [TICK_W-1:0]  exp_tick;
        logic [VEL_W-1:0]   exp_vel;
    } directed_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // start_tick[31:0], note_velocity[38:32], pitch[45:39], duration_ticks[77:46]
    logic [AXIS_DATA_W-1:0] s_axis_tdata = '0;
    // first_in_list[0]
    logic                   s_axis_tuser = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // new_start_tick[31:0], new_velocity[38:32], out_pitch[45:39], out_duration[77:46]
    logic [AXIS_DATA_W-1:0] m_axis_tdata;

    // groove settings and list position as the block should hold them
    logic [63:0]      dev_table   = '0;
    logic [3:0]       dev_count   = '0;
    logic [55:0]      vel_table   = '0;
    logic [3:0]       curve_count = '0;
    logic [15:0]      beat_ticks  = 16'd480;
    logic [8:0]       intensity   = 9'd256;
    logic [8:0]       swing       = 9'd128;
    logic [2:0]       enables     = EN_ALL;
    logic [POS_W-1:0] position    = '0;

    groove_result_t pending_notes[$];
    int gap_max         = 4;
    int hold_off_len    = 0;
    int notes_sent      = 0;
    int notes_checked   = 0;
    int settings_loaded = 0;
    int mismatch_count  = 0;
    int cycle_count     = 0;

    directed_row_t directed_rows [23] = '{
        '{PH_RESET, 32'h0000_0000, 7'd0, 7'd0, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 7'd0},
        '{PH_RESET, 32'hFFFF_FFFF, 7'd127, 7'd127, 32'hFFFF_FFFF, 1'b0, 1'b1,
          32'hFFFF_FFFF, 7'd127},
        '{PH_RESET, 32'h5555_5555, 7'h55, 7'h2A, 32'hAAAA_AAAA, 1'b0, 1'b1,
          32'h5555_5555, 7'h55},
        '{PH_RESET, 32'hAAAA_AAAA, 7'h2A, 7'h55, 32'h5555_5555, 1'b0, 1'b1,
          32'hAAAA_AAAA, 7'h2A},
        '{PH_TIMING, 32'd0, 7'd100, 7'd60, 32'd960, 1'b1, 1'b1, 32'd0, 7'd100},
        '{PH_TIMING, 32'hFFFF_FFFF, 7'd1, 7'd61, 32'd1, 1'b0, 1'b1, 32'hFFFF_FFFF, 7'd1},
        '{PH_TIMING, 32'd240, 7'd90, 7'd62, 32'd120, 1'b0, 1'b0, '0, '0},
        '{PH_TIMING, 32'd1000, 7'd80, 7'd63, 32'd240, 1'b0, 1'b0, '0, '0},
        '{PH_TIMING, 32'd240, 7'd70, 7'd64, 32'd480, 1'b1, 1'b0, '0, '0},
        '{PH_TIMING, 32'd700, 7'd60, 7'd65, 32'd100, 1'b0, 1'b0, '0, '0},
        '{PH_OVERRANGE, 32'd0, 7'd0, 7'd36, 32'd10, 1'b1, 1'b0, '0, '0},
        '{PH_OVERRANGE, 32'd1, 7'd127, 7'd38, 32'd10, 1'b0, 1'b0, '0, '0},
        '{PH_OVERRANGE, 32'd2, 7'd64, 7'd40, 32'd10, 1'b0, 1'b0, '0, '0},
        '{PH_OVERRANGE, 32'd3, 7'd5, 7'd42, 32'd10, 1'b0, 1'b0, '0, '0},
        '{PH_OVERRANGE, 32'hFFFF_FFFF, 7'd127, 7'd44, 32'd10, 1'b0, 1'b0, '0, '0},
        '{PH_NO_TIMING, 32'd100, 7'd0, 7'd48, 32'd20, 1'b1, 1'b1, 32'd100, 7'd1},
        '{PH_NO_TIMING, 32'd32767, 7'd127, 7'd49, 32'd20, 1'b0, 1'b1, 32'd32767, 7'd127},
        '{PH_NO_TIMING, 32'd70000, 7'd50, 7'd50, 32'd20, 1'b0, 1'b1, 32'd70000, 7'd50},
        '{PH_NO_TIMING, 32'd0, 7'd1, 7'd51, 32'd20, 1'b0, 1'b1, 32'd0, 7'd1},
        '{PH_STALE_POS, 32'd10, 7'd20, 7'd72, 32'd30, 1'b0, 1'b0, '0, '0},
        '{PH_STALE_POS, 32'd11, 7'd40, 7'd73, 32'd30, 1'b0, 1'b0, '0, '0},
        '{PH_STALE_POS, 32'd12, 7'd60, 7'd74, 32'd30, 1'b0, 1'b0, '0, '0},
        '{PH_STALE_POS, 32'd13, 7'd80, 7'd75, 32'd30, 1'b0, 1'b0, '0, '0}
    };

    midi_note_groove_applier DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint clamp_tick(input longint t);
        if (t < 0)
        begin
            return 0;
        end
        if (t > TICK_MAX)
        begin
            return TICK_MAX;
        end
        return t;
    endfunction

    // regrooves one note and advances the list position
    function automatic groove_result_t apply_groove(input note_t n);
        groove_result_t r;
        longint t, dev, inten, swg, tpb_e, v, tgt, half, gap_to_half;
        int unsigned dcnt, ccnt, idx;
        int ent;
        t = longint'({32'd0, n.start_tick});
        dcnt = (dev_count > DEVIATION_ENTRIES_DEF) ? DEVIATION_ENTRIES_DEF : dev_count;
        ccnt = (curve_count > CURVE_ENTRIES_DEF) ? CURVE_ENTRIES_DEF : curve_count;
        tpb_e = (beat_ticks < 2) ? 2 : longint'(beat_ticks);
        inten = (intensity > 256) ? 256 : longint'(intensity);
        swg = (swing > 256) ? 256 : longint'(swing);
        idx = n.first_in_list ? 0 : position;
        if (idx >= dcnt)
        begin
            idx = 0;
        end
        if ((enables & EN_TIMING) != 3'b000 && dcnt != 0)
        begin
            dev = longint'($signed(dev_table[8*idx +: 8]));
            t = clamp_tick(t + dev * inten / 256);
        end
        position = (dcnt == 0 || idx + 1 >= dcnt) ? '0 : POS_W'(idx + 1);
        r.velocity = n.velocity;
        if ((enables & EN_VELOCITY) != 3'b000 && ccnt != 0)
        begin
            ent = int'((t / tpb_e) % longint'(ccnt));
            tgt = longint'(vel_table[7*ent +: 7]);
            v = (longint'(n.velocity) * (256 - inten) + tgt * inten) / 256;
            v = (v < 1) ? 1 : ((v > 127) ? 127 : v);
            r.velocity = v[VEL_W-1:0];
        end
        if ((enables & EN_SWING) != 3'b000 && swg != 128)
        begin
            half = tpb_e / 2;
            gap_to_half = (t % tpb_e) - half;
            if (gap_to_half < 0)
            begin
                gap_to_half = -gap_to_half;
            end
            // off-beat: within 0.15 beat of the half-beat
            if (20 * gap_to_half < 3 * tpb_e)
            begin
                t = clamp_tick(t + (swg - 128) * 2 * half * inten / 65536);
            end
        end
        r.start_tick = t[TICK_W-1:0];
        r.pitch = n.pitch;
        r.duration = n.duration;
        return r;
    endfunction

    function automatic note_t random_note(input logic first);
        note_t n;
        longint beat, tick_val;
        beat = (beat_ticks < 2) ? 2 : longint'(beat_ticks);
        case ($urandom_range(0, 3))
            0: tick_val = longint'($urandom);
            1: tick_val = longint'($urandom_range(0, 3000));
            2: tick_val = TICK_MAX - longint'($urandom_range(0, 2000));
            // land near the half-beat so the swing window is hit often
            default: tick_val = longint'($urandom_range(0, 5000)) * beat + beat / 2
                                + longint'($urandom_range(0, 32'(beat / 4))) - beat / 8;
        endcase
        n.start_tick = tick_val[TICK_W-1:0];
        n.velocity = VEL_W'($urandom);
        n.pitch = PITCH_W'($urandom);
        n.duration = $urandom;
        n.first_in_list = first;
        return n;
    endfunction

    // upper bits beyond the register width carry junk the block must ignore
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val,
                             input int w);
        logic [63:0] mask;
        mask = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= ({$urandom, $urandom} & ~mask) | (val & mask);
        case (idx)
            REG_DEV_TABLE: dev_table = val;
            REG_DEV_COUNT: dev_count = val[3:0];
            REG_VEL_TABLE: vel_table = val[55:0];
            REG_CURVE_CNT: curve_count = val[3:0];
            REG_TPB:       beat_ticks = val[15:0];
            REG_INTENSITY: intensity = val[8:0];
            REG_SWING:     swing = val[8:0];
            REG_ENABLE:    enables = val[2:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_groove(input logic [63:0] dt, input logic [3:0] dc,
                               input logic [55:0] vt, input logic [3:0] cc,
                               input logic [15:0] tpb, input logic [8:0] inten,
                               input logic [8:0] swg, input logic [2:0] en);
        cfg_write(REG_DEV_TABLE, dt, 64);
        cfg_write(REG_DEV_COUNT, 64'(dc), 4);
        cfg_write(REG_VEL_TABLE, 64'(vt), 56);
        cfg_write(REG_CURVE_CNT, 64'(cc), 4);
        cfg_write(REG_TPB, 64'(tpb), 16);
        cfg_write(REG_INTENSITY, 64'(inten), 9);
        cfg_write(REG_SWING, 64'(swg), 9);
        cfg_write(REG_ENABLE, 64'(en), 3);
        settings_loaded++;
    endtask

    task automatic send_note(input note_t n, input bit typed, input groove_result_t typed_res);
        groove_result_t predicted;
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, n.duration, n.pitch, n.velocity, n.start_tick};
        s_axis_tuser <= n.first_in_list;
        do @(posedge clk); while (!s_axis_tready);
        predicted = apply_groove(n);
        if (typed)
        begin
            predicted = typed_res;
        end
        pending_notes = {pending_notes, predicted};
        notes_sent++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_notes.size() != 0) @(posedge clk);
    endtask

    // result side: random stalls, one long hold-off on request
    initial
    begin
        groove_result_t got, want;
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = $urandom_range(0, gap_max);
            if (hold_off_len != 0)
            begin
                stall = hold_off_len;
                hold_off_len = 0;
            end
            if (stall != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            got.start_tick = m_axis_tdata[31:0];
            got.velocity = m_axis_tdata[38:32];
            got.pitch = m_axis_tdata[45:39];
            got.duration = m_axis_tdata[77:46];
            if (pending_notes.size() == 0)
            begin
                $error("result with no note pending: new_start_tick %0d", got.start_tick);
                mismatch_count++;
            end
            else
            begin
                want = pending_notes.pop_front();
                notes_checked++;
                if (got.start_tick !== want.start_tick)
                begin
                    $error("new_start_tick: expected %0d, actual %0d",
                           want.start_tick, got.start_tick);
                    mismatch_count++;
                end
                if (got.velocity !== want.velocity)
                begin
                    $error("new_velocity: expected %0d, actual %0d", want.velocity, got.velocity);
                    mismatch_count++;
                end
                if (got.pitch !== want.pitch)
                begin
                    $error("out_pitch: expected %0d, actual %0d", want.pitch, got.pitch);
                    mismatch_count++;
                end
                if (got.duration !== want.duration)
                begin
                    $error("out_duration: expected %0d, actual %0d", want.duration, got.duration);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("midi_note_groove_applier test failed");
        $finish;
    end

    initial
    begin
        directed_row_t row;
        note_t n;
        groove_result_t typed_res;
        int cur_phase, list_left;
        logic first;
        logic [15:0] tpb_pick;
        logic [8:0] inten_pick, swing_pick;
        logic [3:0] dc_pick, cc_pick;
        logic [2:0] en_pick;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        cur_phase = PH_RESET;
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.phase != cur_phase)
            begin
                wait_idle();
                cur_phase = row.phase;
                case (cur_phase)
                    PH_TIMING:
                        load_groove(64'h0000_0000_FB05_7F80, 4'd3, 56'd0, 4'd0, 16'd480,
                                    9'd256, 9'd256, EN_ALL);
                    // counts, beat length and strengths beyond their limits
                    PH_OVERRANGE:
                        load_groove(64'h7F80_01FF_40C0_10F0, 4'hF, 56'hFE_007F_013F_402A,
                                    4'hC, 16'd1, 9'h1FF, 9'd400, EN_ALL);
                    // position keeps moving with timing off
                    PH_NO_TIMING:
                        load_groove(64'h0102_0304_0506_0708, 4'd5, 56'd0, 4'd8, 16'hFFFF,
                                    9'd0, 9'd0, EN_VELOCITY | EN_SWING);
                    // stored position left beyond the shorter table
                    PH_STALE_POS:
                        load_groove(64'h0000_0000_00C0_4020, 4'd3, 56'h7F_0000_0040_0001,
                                    4'd4, 16'd3, 9'd128, 9'd200, EN_ALL);
                    default: ;
                endcase
            end
            n = '{row.tick, row.vel, row.pitch, row.dur, row.first};
            typed_res = '{row.exp_tick, row.exp_vel, row.pitch, row.dur};
            send_note(n, row.typed, typed_res);
        end
        wait_idle();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            dc_pick = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                  : 4'($urandom_range(1, 8));
            cc_pick = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                  : 4'($urandom_range(1, 8));
            case ($urandom_range(0, 5))
                0: tpb_pick = 16'($urandom_range(0, 1));
                1: tpb_pick = 16'($urandom_range(2, 3));
                2: tpb_pick = 16'hFFFF;
                5: tpb_pick = 16'($urandom);
                default: tpb_pick = 16'($urandom_range(4, 1000));
            endcase
            case ($urandom_range(0, 4))
                0: inten_pick = 9'd0;
                1: inten_pick = 9'd256;
                4: inten_pick = 9'($urandom_range(257, 511));
                default: inten_pick = 9'($urandom_range(0, 256));
            endcase
            case ($urandom_range(0, 4))
                0: swing_pick = 9'd128;
                1: swing_pick = 9'd0;
                2: swing_pick = 9'd256;
                default: swing_pick = 9'($urandom_range(0, 511));
            endcase
            en_pick = ($urandom_range(0, 1) == 1) ? EN_ALL : 3'($urandom_range(0, 7));
            load_groove({$urandom, $urandom}, dc_pick, 56'({$urandom, $urandom}), cc_pick,
                        tpb_pick, inten_pick, swing_pick, en_pick);
            gap_max = (ph == 2) ? 0 : 4;
            if (ph == 5)
            begin
                hold_off_len = LONG_HOLD;
            end
            list_left = 0;
            first = 1'b0;
            for (int k = 0; k < NOTES_PER_PHASE; k++)
            begin
                // mostly whole lists; now and then a list with no start mark
                if (list_left == 0)
                begin
                    list_left = $urandom_range(1, 12);
                    first = ($urandom_range(0, 7) != 0);
                end
                send_note(random_note(first), 1'b0, typed_res);
                list_left--;
                first = 1'b0;
            end
            wait_idle();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_notes.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_notes.size());
            mismatch_count++;
        end
        $display("%0d notes sent, %0d results checked, %0d groove settings loaded",
                 notes_sent, notes_checked, settings_loaded);
        $display("covered table wrap, stale position, clamp and saturation, swing, long stall");
        if (mismatch_count == 0)
        begin
            $display("midi_note_groove_applier test passed");
        end
        else
        begin
            $display("midi_note_groove_applier test failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/mnga_pkg.sv
design/mnga_div.sv
design/midi_note_groove_applier.sv
tb/tb_top.sv
